// File: rtl/core/dsr_pkg.sv
// Shared types, codes and constants of the debounced switch reporter.
// Also holds the elaboration-time builder of the breathing brightness ROM.
// Depends on nothing; every other file of the block uses it.
package dsr_pkg;

   // Operation codes carried by an input word
   typedef enum logic [2:0] {
      OP_SAMPLE = 3'd0,
      OP_ACK    = 3'd1,
      OP_ERROR  = 3'd2,
      OP_TICK   = 3'd3,
      OP_QUERY  = 3'd4
   } op_type;

   // Kinds of result word
   typedef enum logic [1:0] {
      MSG_STATE  = 2'd0,
      MSG_PING   = 2'd1,
      MSG_BRIGHT = 2'd2
   } msg_kind_type;

   // State as confirmed by the far end
   typedef enum logic [1:0] {
      CONF_UNKNOWN = 2'd0,
      CONF_ON      = 2'd1,
      CONF_OFF     = 2'd2,
      CONF_ERROR   = 2'd3
   } conf_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_DEBOUNCE  = 2'd0,
      CSR_RETRY     = 2'd1,
      CSR_HEARTBEAT = 2'd2
   } csr_index_type;

   localparam int CSR_W  = 16;
   localparam int TIME_W = 32;
   localparam int SEQ_W  = 32;
   localparam int LED_W  = 8;

   localparam logic [CSR_W-1:0] DEBOUNCE_RESET  = 16'd50;
   localparam logic [CSR_W-1:0] RETRY_RESET     = 16'd500;
   localparam logic [CSR_W-1:0] HEARTBEAT_RESET = 16'd5000;

   localparam logic [LED_W-1:0] LED_FULL = 8'hFF;
   localparam logic [LED_W-1:0] LED_OFF  = 8'h00;

   // Blink half period; the breathing period is a whole number of these
   localparam int BLINK_HALF    = 125;
   localparam int BREATH_PERIOD = 2000;
   localparam int BREATH_BLOCKS = BREATH_PERIOD / BLINK_HALF;
   localparam int BLK_W         = $clog2(BREATH_BLOCKS);
   localparam int PHASE_W       = $clog2(BREATH_PERIOD) + 1;
   localparam int REM_W         = $clog2(BLINK_HALF);

   // ROM covers one half of the symmetric breathing curve
   localparam int BREATH_DEPTH = BREATH_PERIOD / 2 + 1;
   localparam int ADDR_W       = $clog2(BREATH_DEPTH);

   // now / 125 as (now * ceil(2^39 / 125)) >> 39, exact for all 32-bit now
   localparam int              RECIP_SHIFT = 39;
   localparam int              RECIP_W     = 33;
   localparam logic [RECIP_W-1:0] RECIP_HALF = 33'd4398046512;
   localparam int              QUOT_W      = 26;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   // pi in Q60 split by the breathing period
   localparam logic [63:0] PI_DIV_P = PI_Q60 / 64'(BREATH_PERIOD);
   localparam logic [63:0] PI_MOD_P = PI_Q60 % 64'(BREATH_PERIOD);

   // Item leaving the control stage
   typedef struct packed {
      logic                valid;
      logic [1:0]          n_res;
      msg_kind_type        kind0;
      msg_kind_type        kind1;
      logic [SEQ_W-1:0]    seq;
      logic                state_on;
      conf_type            conf;
      logic [TIME_W-1:0]   now;
   } item_type;

   // Item leaving the brightness pipeline
   typedef struct packed {
      logic                valid;
      logic [1:0]          n_res;
      msg_kind_type        kind0;
      msg_kind_type        kind1;
      logic [SEQ_W-1:0]    seq;
      logic                state_on;
      logic [LED_W-1:0]    brightness;
   } res_type;

   typedef logic [BREATH_DEPTH-1:0][LED_W-1:0] breath_rom_type;

   // (a * b) >> 60 in Q60, truncated to 64 bits
   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // Truncating 64-bit quotient by shift and subtract; table building only
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // floor(255 * sin(pi*q/P)^2) in Q60, Taylor series up to the 27th power
   function automatic logic [LED_W-1:0] breath_value(int unsigned q);
      logic [63:0] q64;
      logic [63:0] per;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] s2;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] res;
      q64 = 64'(q);
      per = 64'(BREATH_PERIOD);
      if (q64 == 64'd0) return LED_OFF;
      if (q64 * 64'd2 == per) return LED_FULL;
      t = PI_DIV_P * q64 + udiv64(PI_MOD_P * q64, per);
      t2 = qmul(t, t);
      term = t;
      s = t;
      for (int n = 1; n <= 13; n++) begin
         term = udiv64(qmul(term, t2), 64'((2 * n) * (2 * n + 1)));
         if (n[0]) s = s - term;
         else s = s + term;
      end
      s2 = qmul(s, s);
      hi = s2 >> 32;
      lo = s2 & 64'hFFFF_FFFF;
      res = ((64'd255 * hi) + ((64'd255 * lo) >> 32)) >> 28;
      return res[LED_W-1:0];
   endfunction

   function automatic breath_rom_type build_breath_rom();
      breath_rom_type rom;
      for (int i = 0; i < BREATH_DEPTH; i++) begin
         rom[i] = breath_value(i);
      end
      return rom;
   endfunction

endpackage

// File: rtl/core/dsr_ctrl.sv
// Input register, configuration registers and the debounce / ack / retry /
// heartbeat state. Decides the result words of each input word.
// Depends on dsr_pkg.
module dsr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          req_valid,
   input  logic [2:0]                    req_opcode,
   input  logic [dsr_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                          req_level_on,
   input  logic [dsr_pkg::SEQ_W-1:0]     req_seq_in,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [dsr_pkg::CSR_W-1:0]     csr_wdata,
   output dsr_pkg::item_type             item
);

   // Configuration registers
   logic [dsr_pkg::CSR_W-1:0] debounce_ff;
   logic [dsr_pkg::CSR_W-1:0] retry_ff;
   logic [dsr_pkg::CSR_W-1:0] heartbeat_ff;

   // Input register
   logic                        s1_valid_ff;
   logic [2:0]                  s1_op_ff;
   logic [dsr_pkg::TIME_W-1:0]  s1_now_ff;
   logic                        s1_level_ff;
   logic [dsr_pkg::SEQ_W-1:0]   s1_seq_ff;

   // Switch / protocol state
   logic                        have_cand_ff, have_cand_in;
   logic                        cand_level_ff, cand_level_in;
   logic [dsr_pkg::TIME_W-1:0]  cand_since_ff, cand_since_in;
   logic                        have_stable_ff, have_stable_in;
   logic                        stable_ff, stable_in;
   logic [dsr_pkg::SEQ_W-1:0]   seq_count_ff, seq_count_in;
   logic                        awaiting_ff, awaiting_in;
   dsr_pkg::conf_type           conf_ff, conf_in;
   logic [dsr_pkg::TIME_W-1:0]  last_state_ff, last_state_in;
   logic [dsr_pkg::TIME_W-1:0]  last_hb_ff, last_hb_in;

   dsr_pkg::item_type           item_ff, item_in;

   logic                        fire;
   logic                        debounce_done;
   logic                        retry_due;
   logic                        hb_due;

   assign fire = s1_valid_ff && adv;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= dsr_pkg::DEBOUNCE_RESET;
         retry_ff     <= dsr_pkg::RETRY_RESET;
         heartbeat_ff <= dsr_pkg::HEARTBEAT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            dsr_pkg::CSR_DEBOUNCE:  debounce_ff  <= csr_wdata;
            dsr_pkg::CSR_RETRY:     retry_ff     <= csr_wdata;
            dsr_pkg::CSR_HEARTBEAT: heartbeat_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
      if (adv && req_valid) begin
         s1_op_ff    <= req_opcode;
         s1_now_ff   <= req_now_ms;
         s1_level_ff <= req_level_on;
         s1_seq_ff   <= req_seq_in;
      end
   end

   // Wrapping elapsed-time checks
   assign debounce_done = (s1_now_ff - cand_since_ff) >= {16'd0, debounce_ff};
   assign retry_due     = (s1_now_ff - last_state_ff) >= {16'd0, retry_ff};
   assign hb_due        = (s1_now_ff - last_hb_ff) >= {16'd0, heartbeat_ff};

   // Next state and result words of the word in the input register
   always_comb begin
      have_cand_in   = have_cand_ff;
      cand_level_in  = cand_level_ff;
      cand_since_in  = cand_since_ff;
      have_stable_in = have_stable_ff;
      stable_in      = stable_ff;
      seq_count_in   = seq_count_ff;
      awaiting_in    = awaiting_ff;
      conf_in        = conf_ff;
      last_state_in  = last_state_ff;
      last_hb_in     = last_hb_ff;
      item_in.valid  = s1_valid_ff;
      item_in.n_res  = 2'd0;
      item_in.kind0  = dsr_pkg::MSG_STATE;
      item_in.kind1  = dsr_pkg::MSG_PING;
      unique case (s1_op_ff)
         dsr_pkg::OP_SAMPLE: begin
            if (!have_cand_ff || (s1_level_ff != cand_level_ff)) begin
               cand_level_in = s1_level_ff;
               cand_since_in = s1_now_ff;
               have_cand_in  = 1'b1;
            end else if (debounce_done &&
                         (!have_stable_ff || (s1_level_ff != stable_ff))) begin
               stable_in      = s1_level_ff;
               have_stable_in = 1'b1;
               seq_count_in   = seq_count_ff + 1'b1;
               awaiting_in    = 1'b1;
               conf_in        = dsr_pkg::CONF_UNKNOWN;
               last_state_in  = s1_now_ff;
               item_in.n_res  = 2'd1;
            end
         end
         dsr_pkg::OP_ACK: begin
            if (awaiting_ff && (s1_seq_ff == seq_count_ff) &&
                (s1_level_ff == stable_ff)) begin
               awaiting_in = 1'b0;
               conf_in     = s1_level_ff ? dsr_pkg::CONF_ON : dsr_pkg::CONF_OFF;
            end
         end
         dsr_pkg::OP_ERROR: begin
            if (s1_seq_ff == seq_count_ff) begin
               awaiting_in = 1'b0;
               conf_in     = dsr_pkg::CONF_ERROR;
            end
         end
         dsr_pkg::OP_TICK: begin
            // state re-send goes first, ping after it
            if (awaiting_ff && retry_due) begin
               last_state_in = s1_now_ff;
               if (hb_due) begin
                  last_hb_in    = s1_now_ff;
                  item_in.n_res = 2'd2;
               end else begin
                  item_in.n_res = 2'd1;
               end
            end else if (hb_due) begin
               last_hb_in    = s1_now_ff;
               item_in.n_res = 2'd1;
               item_in.kind0 = dsr_pkg::MSG_PING;
            end
         end
         dsr_pkg::OP_QUERY: begin
            item_in.n_res = 2'd1;
            item_in.kind0 = dsr_pkg::MSG_BRIGHT;
         end
         default: ;
      endcase
      item_in.seq      = seq_count_in;
      item_in.state_on = stable_in;
      item_in.conf     = conf_ff;
      item_in.now      = s1_now_ff;
   end

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         have_cand_ff   <= 1'b0;
         cand_level_ff  <= 1'b0;
         cand_since_ff  <= '0;
         have_stable_ff <= 1'b0;
         stable_ff      <= 1'b0;
         seq_count_ff   <= '0;
         awaiting_ff    <= 1'b0;
         conf_ff        <= dsr_pkg::CONF_UNKNOWN;
         last_state_ff  <= '0;
         last_hb_ff     <= '0;
      end else if (fire) begin
         have_cand_ff   <= have_cand_in;
         cand_level_ff  <= cand_level_in;
         cand_since_ff  <= cand_since_in;
         have_stable_ff <= have_stable_in;
         stable_ff      <= stable_in;
         seq_count_ff   <= seq_count_in;
         awaiting_ff    <= awaiting_in;
         conf_ff        <= conf_in;
         last_state_ff  <= last_state_in;
         last_hb_ff     <= last_hb_in;
      end
   end

   // Decision register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (adv) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

// File: rtl/core/dsr_bright.sv
// LED brightness pipeline: divide time by the blink half period, fold the
// breathing phase onto the ROM, read the ROM, pick by confirmed state.
// Depends on dsr_pkg.
module dsr_bright (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  dsr_pkg::item_type   item,
   output dsr_pkg::res_type    res
);

   localparam dsr_pkg::breath_rom_type BREATH_ROM = dsr_pkg::build_breath_rom();

   localparam int PROD_W = dsr_pkg::TIME_W + dsr_pkg::RECIP_W;

   dsr_pkg::item_type                s3_ff;
   logic [dsr_pkg::QUOT_W-1:0]       quot_ff;
   dsr_pkg::item_type                s4_ff;
   logic [dsr_pkg::LED_W-1:0]        rom_ff;
   logic                             blink_on_ff;

   logic [PROD_W-1:0]                prod;
   logic [dsr_pkg::TIME_W:0]         quot_x125;
   logic [dsr_pkg::TIME_W-1:0]       diff;
   logic [dsr_pkg::PHASE_W-1:0]      phase;
   logic [dsr_pkg::PHASE_W-1:0]      folded;
   logic [dsr_pkg::ADDR_W-1:0]       rom_addr;
   logic [dsr_pkg::LED_W-1:0]        led;

   // Quotient by the blink half period through the reciprocal
   assign prod = {{dsr_pkg::RECIP_W{1'b0}}, item.now} *
                 {{dsr_pkg::TIME_W{1'b0}}, dsr_pkg::RECIP_HALF};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s3_ff   <= item;
         quot_ff <= prod[dsr_pkg::RECIP_SHIFT +: dsr_pkg::QUOT_W];
      end
   end

   // Remainder, breathing phase and fold onto the rising half
   assign quot_x125 = {quot_ff, 7'd0} - {5'd0, quot_ff, 2'd0} + {7'd0, quot_ff};
   assign diff      = s3_ff.now - quot_x125[dsr_pkg::TIME_W-1:0];
   assign phase     = dsr_pkg::PHASE_W'(quot_ff[dsr_pkg::BLK_W-1:0]) *
                      dsr_pkg::PHASE_W'(dsr_pkg::BLINK_HALF) +
                      dsr_pkg::PHASE_W'(diff[dsr_pkg::REM_W-1:0]);
   assign folded    = ({phase, 1'b0} > (dsr_pkg::PHASE_W + 1)'(dsr_pkg::BREATH_PERIOD)) ?
                      dsr_pkg::PHASE_W'(dsr_pkg::BREATH_PERIOD) - phase : phase;
   assign rom_addr  = folded[dsr_pkg::ADDR_W-1:0];

   // ROM read, registered
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff.valid <= 1'b0;
      end else if (adv) begin
         s4_ff       <= s3_ff;
         rom_ff      <= BREATH_ROM[rom_addr];
         blink_on_ff <= ~quot_ff[0];
      end
   end

   // Brightness by confirmed state
   always_comb begin
      unique case (s4_ff.conf)
         dsr_pkg::CONF_ON:    led = dsr_pkg::LED_FULL;
         dsr_pkg::CONF_OFF:   led = dsr_pkg::LED_OFF;
         dsr_pkg::CONF_ERROR: led = blink_on_ff ? dsr_pkg::LED_FULL : dsr_pkg::LED_OFF;
         default:             led = rom_ff;
      endcase
   end

   assign res.valid      = s4_ff.valid;
   assign res.n_res      = s4_ff.n_res;
   assign res.kind0      = s4_ff.kind0;
   assign res.kind1      = s4_ff.kind1;
   assign res.seq        = s4_ff.seq;
   assign res.state_on   = s4_ff.state_on;
   assign res.brightness = (s4_ff.kind0 == dsr_pkg::MSG_BRIGHT) ? led : dsr_pkg::LED_OFF;

endmodule

// File: rtl/core/dsr_out.sv
// Result register: holds the one or two result words of an input word and
// hands them out one per cycle while not stalled. Drives the pipeline advance.
// Depends on dsr_pkg.
module dsr_out (
   input  logic                          clock,
   input  logic                          reset,
   input  dsr_pkg::res_type              res,
   output logic                          adv,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_msg_kind,
   output logic [dsr_pkg::SEQ_W-1:0]     rsp_seq_out,
   output logic                          rsp_state_on,
   output logic [dsr_pkg::LED_W-1:0]     rsp_brightness,
   output logic                          rsp_last_result
);

   logic [1:0]                   cnt_ff;
   dsr_pkg::msg_kind_type        kind_ff;
   dsr_pkg::msg_kind_type        kind_next_ff;
   logic [dsr_pkg::SEQ_W-1:0]    seq_ff;
   logic                         state_ff;
   logic [dsr_pkg::LED_W-1:0]    bright_ff;

   logic pop;
   logic load;

   assign pop  = (cnt_ff != 2'd0) && !rsp_stall;
   // free once the last held word leaves this cycle
   assign adv  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rsp_stall);
   assign load = adv && res.valid && (res.n_res != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= res.n_res;
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
      if (load) begin
         kind_ff      <= res.kind0;
         kind_next_ff <= res.kind1;
         seq_ff       <= res.seq;
         state_ff     <= res.state_on;
         bright_ff    <= res.brightness;
      end else if (pop) begin
         kind_ff <= kind_next_ff;
      end
   end

   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_msg_kind    = kind_ff;
   assign rsp_seq_out     = seq_ff;
   assign rsp_state_on    = state_ff;
   assign rsp_brightness  = bright_ff;
   assign rsp_last_result = (cnt_ff == 2'd1);

endmodule

// File: rtl/core/debounced_switch_report_with_ack_retry_top.sv
// Top level of the debounced switch reporter with ack, retry and heartbeat.
// Instantiates dsr_ctrl, dsr_bright and dsr_out; depends on dsr_pkg.
//
// The block takes one input word per cycle and hands out result words one
// per cycle while the receiver does not stall, so its sustained rate is one
// input word per cycle; the rate falls while ticks that cause both a state
// re-send and a ping arrive, since the result register releases one word a
// cycle. A word passes the input register, decision register, reciprocal
// multiply, brightness ROM read and result register before it leaves. The
// whole pipeline stalls together while the result register cannot take a
// new word. The breathing brightness comes from a 1001-entry ROM holding
// one half of the curve; configuration writes take effect at once.
module debounced_switch_report_with_ack_retry_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_opcode,
   input  logic [dsr_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                          req_level_on,
   input  logic [dsr_pkg::SEQ_W-1:0]     req_seq_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_msg_kind,
   output logic [dsr_pkg::SEQ_W-1:0]     rsp_seq_out,
   output logic                          rsp_state_on,
   output logic [dsr_pkg::LED_W-1:0]     rsp_brightness,
   output logic                          rsp_last_result,
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [dsr_pkg::CSR_W-1:0]     csr_wdata
);

   logic               adv;
   dsr_pkg::item_type  item;
   dsr_pkg::res_type   res;

   assign req_stall = !adv;

   dsr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .req_valid    (req_valid),
      .req_opcode   (req_opcode),
      .req_now_ms   (req_now_ms),
      .req_level_on (req_level_on),
      .req_seq_in   (req_seq_in),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item         (item)
   );

   dsr_bright u_bright (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .item  (item),
      .res   (res)
   );

   dsr_out u_out (
      .clock           (clock),
      .reset           (reset),
      .res             (res),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_msg_kind    (rsp_msg_kind),
      .rsp_seq_out     (rsp_seq_out),
      .rsp_state_on    (rsp_state_on),
      .rsp_brightness  (rsp_brightness),
      .rsp_last_result (rsp_last_result)
   );

endmodule

// File: rtl/core/dsr_checker.sv
// Port-level checks of the debounced switch reporter, bound to its top level.
// Depends on dsr_pkg.
module dsr_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [1:0]                    rsp_msg_kind,
   input  logic [dsr_pkg::LED_W-1:0]     rsp_brightness,
   input  logic                          rsp_last_result
);

   // A held result word stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Only brightness replies carry a brightness
   a_bright_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_msg_kind != dsr_pkg::MSG_BRIGHT) |-> rsp_brightness == '0)
      else $error("brightness on a non-brightness word");

   // Brightness replies and pings always close their input word
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_msg_kind == dsr_pkg::MSG_BRIGHT) ||
                    (rsp_msg_kind == dsr_pkg::MSG_PING)) |-> rsp_last_result)
      else $error("reply or ping not marked last");

   // A non-final state report is followed at once by its ping
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_result |=>
         rsp_valid && (rsp_msg_kind == dsr_pkg::MSG_PING))
      else $error("second word of a tick missing");

endmodule

bind debounced_switch_report_with_ack_retry_top dsr_checker u_dsr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_msg_kind    (rsp_msg_kind),
   .rsp_brightness  (rsp_brightness),
   .rsp_last_result (rsp_last_result)
);

// File: bench/debounced_switch_report_with_ack_retry_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the debounced switch reporter: drives operation words, predicts
// every state report, ping and brightness reply, and checks them in order of arrival.
// Depends on dsr_pkg and debounced_switch_report_with_ack_retry_top.
module debounced_switch_report_with_ack_retry_top_test;
   import dsr_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int PIPE_SLACK   = 12;    // pipeline drain plus margin
   localparam int STALL_LIMIT  = 5000;  // cycles with no word moving on either side
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int PHASE_WORDS  = 68;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam logic [2:0] OP_SPARE5 = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   // One expected result word
   typedef struct {
      msg_kind_type      kind;
      logic [SEQ_W-1:0]  seq;
      logic              on;
      logic [LED_W-1:0]  led;
      logic              last;
   } report_t;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_opcode = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 req_level_on = 1'b0;
   logic [SEQ_W-1:0]     req_seq_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_msg_kind;
   logic [SEQ_W-1:0]     rsp_seq_out;
   logic                 rsp_state_on;
   logic [LED_W-1:0]     rsp_brightness;
   logic                 rsp_last_result;
   logic                 csr_write = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Predicted block state and register copies
   logic [CSR_W-1:0]     debounce_cfg, retry_cfg, heartbeat_cfg;
   logic                 cand_seen, cand_lvl, stable_seen, stable_lvl, ack_wait;
   logic [TIME_W-1:0]    cand_since, state_sent_at, ping_sent_at;
   logic [SEQ_W-1:0]     seq_now;
   conf_type             conf_now;

   report_t              awaited_msgs[$];
   logic [TIME_W-1:0]    now_ms_sim;
   bit                   calm = 1'b0;
   int                   words_sent = 0;
   int                   msgs_checked = 0;
   int                   error_count = 0;
   int                   phases_run = 0;
   int                   quiet_cycles = 0;
   int                   hold_left = 0;
   int                   holds_served = 0;
   int                   holds_asked = 0;

   debounced_switch_report_with_ack_retry_top uut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = 128'(a) * 128'(b);
      return 64'(wide >> 60);
   endfunction

   // floor(255 * sin(pi*p/P)^2) in Q60, sine by truncated Taylor series
   function automatic logic [LED_W-1:0] breathing_led(input logic [TIME_W-1:0] now);
      logic [63:0] span, ph, ang, ang_sq, term, sine, sine_sq, led;
      span = 64'(BREATH_PERIOD);
      ph = 64'(now) % span;
      if (2 * ph > span) ph = span - ph;
      if (ph == 0) return LED_OFF;
      if (2 * ph == span) return LED_FULL;
      ang = (PI_Q60 / span) * ph + ((PI_Q60 % span) * ph) / span;
      ang_sq = q60_mul(ang, ang);
      term = ang;
      sine = ang;
      for (int k = 1; k <= 13; k++) begin
         term = q60_mul(term, ang_sq) / 64'(2 * k * (2 * k + 1));
         sine = k[0] ? sine - term : sine + term;
      end
      sine_sq = q60_mul(sine, sine);
      led = (64'd255 * (sine_sq >> 32) + ((64'd255 * (sine_sq & 64'hFFFF_FFFF)) >> 32)) >> 28;
      return led[LED_W-1:0];
   endfunction

   // wrapping elapsed time
   function automatic logic [TIME_W-1:0] ms_since(input logic [TIME_W-1:0] now,
                                                  input logic [TIME_W-1:0] since);
      return now - since;
   endfunction

   function automatic report_t report_of(input msg_kind_type kind,
                                         input logic [LED_W-1:0] shade);
      report_t r;
      r.kind = kind;
      r.seq  = seq_now;
      r.on   = stable_lvl;
      r.led  = shade;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic predict_messages(input logic [2:0] op, input logic [TIME_W-1:0] now,
                                   input logic lvl, input logic [SEQ_W-1:0] seq);
      report_t          made[$];
      logic [LED_W-1:0] shade;
      case (op)
         OP_SAMPLE: begin
            if (!cand_seen || lvl != cand_lvl) begin
               cand_seen  = 1'b1;
               cand_lvl   = lvl;
               cand_since = now;
            end else if (ms_since(now, cand_since) >= debounce_cfg &&
                         (!stable_seen || lvl != stable_lvl)) begin
               stable_seen = 1'b1;
               stable_lvl  = lvl;
               seq_now     = seq_now + 1;
               ack_wait    = 1'b1;
               conf_now    = CONF_UNKNOWN;
               made.push_back(report_of(MSG_STATE, LED_OFF));
               state_sent_at = now;
            end
         end
         OP_ACK: begin
            if (ack_wait && seq == seq_now && lvl == stable_lvl) begin
               ack_wait = 1'b0;
               conf_now = lvl ? CONF_ON : CONF_OFF;
            end
         end
         OP_ERROR: begin
            // no pending acknowledge needed here
            if (seq == seq_now) begin
               ack_wait = 1'b0;
               conf_now = CONF_ERROR;
            end
         end
         OP_TICK: begin
            if (ack_wait && ms_since(now, state_sent_at) >= retry_cfg) begin
               made.push_back(report_of(MSG_STATE, LED_OFF));
               state_sent_at = now;
            end
            if (ms_since(now, ping_sent_at) >= heartbeat_cfg) begin
               made.push_back(report_of(MSG_PING, LED_OFF));
               ping_sent_at = now;
            end
         end
         OP_QUERY: begin
            case (conf_now)
               CONF_ON:    shade = LED_FULL;
               CONF_OFF:   shade = LED_OFF;
               CONF_ERROR: shade = (now % (2 * BLINK_HALF) < BLINK_HALF) ? LED_FULL : LED_OFF;
               default:    shade = breathing_led(now);
            endcase
            made.push_back(report_of(MSG_BRIGHT, shade));
         end
         default: ;
      endcase
      if (made.size() != 0) made[made.size() - 1].last = 1'b1;
      foreach (made[i]) awaited_msgs.push_back(made[i]);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10) $display("MISMATCH: %s", what);
   endtask

   always @(posedge clock) begin
      report_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_msgs.size() == 0) begin
            flag_error($sformatf("unexpected word kind %0d seq %0h on %0b led %0d last %0b",
                                 rsp_msg_kind, rsp_seq_out, rsp_state_on, rsp_brightness,
                                 rsp_last_result));
         end else begin
            want = awaited_msgs.pop_front();
            msgs_checked++;
            if (rsp_msg_kind !== want.kind || rsp_seq_out !== want.seq ||
                rsp_state_on !== want.on || rsp_brightness !== want.led ||
                rsp_last_result !== want.last)
               flag_error($sformatf({"exp/got kind %0d/%0d seq %0h/%0h on %0b/%0b ",
                                     "led %0d/%0d last %0b/%0b"},
                                    want.kind, rsp_msg_kind, want.seq, rsp_seq_out,
                                    want.on, rsp_state_on, want.led, rsp_brightness,
                                    want.last, rsp_last_result));
         end
      end
   end

   // watchdog: nothing accepted on either side for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no word moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // receiver: random stalls, quiet stretches, and long hold-offs on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 22);
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_word(input logic [2:0] op, input logic [TIME_W-1:0] now,
                            input logic lvl, input logic [SEQ_W-1:0] seq);
      if (!calm && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_now_ms   <= now;
      req_level_on <= lvl;
      req_seq_in   <= seq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_messages(op, now, lvl, seq);
      if (op <= OP_QUERY) words_sent++;
   endtask

   // stop sending, let every expected word arrive, then let the pipe empty
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (awaited_msgs.size() != 0) @(posedge clock);
      repeat (PIPE_SLACK) @(posedge clock);
   endtask

   task automatic poke_register(input logic [1:0] idx, input logic [CSR_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_DEBOUNCE:  debounce_cfg  = data;
         CSR_RETRY:     retry_cfg     = data;
         CSR_HEARTBEAT: heartbeat_cfg = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_W-1:0] deb, input logic [CSR_W-1:0] rty,
                             input logic [CSR_W-1:0] hb);
      pause_until_drained();
      poke_register(CSR_DEBOUNCE, deb);
      poke_register(CSR_RETRY, rty);
      poke_register(CSR_HEARTBEAT, hb);
   endtask

   // one random scenario; mostly well-formed, some noise
   task automatic random_item();
      int                pick;
      logic              lvl;
      logic [TIME_W-1:0] hold;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // switch change, sometimes bouncing first, then a confirming sample
         lvl = ($urandom_range(0, 99) < 80) ? !stable_lvl : 1'($urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0) begin
            send_word(OP_SAMPLE, now_ms_sim, !lvl, $urandom);
            now_ms_sim += $urandom_range(0, 20);
         end
         send_word(OP_SAMPLE, now_ms_sim, lvl, $urandom);
         case ($urandom_range(0, 9))
            0:       hold = debounce_cfg;
            1, 2:    hold = $urandom_range(0, debounce_cfg);
            default: hold = debounce_cfg + $urandom_range(0, 30);
         endcase
         now_ms_sim += hold;
         send_word(OP_SAMPLE, now_ms_sim, lvl, $urandom);
      end else if (pick < 45) begin
         case ($urandom_range(0, 5))
            0:       send_word(OP_ACK, $urandom, stable_lvl, seq_now + 1);
            1:       send_word(OP_ACK, $urandom, !stable_lvl, seq_now);
            2:       send_word(OP_ACK, $urandom, 1'($urandom_range(0, 1)), $urandom);
            default: send_word(OP_ACK, $urandom, stable_lvl, seq_now);
         endcase
      end else if (pick < 52) begin
         if ($urandom_range(0, 1))
            send_word(OP_ERROR, $urandom, 1'($urandom_range(0, 1)), seq_now);
         else
            send_word(OP_ERROR, $urandom, 1'($urandom_range(0, 1)),
                      seq_now ^ (32'd1 << $urandom_range(0, 31)));
      end else if (pick < 72) begin
         // ticks on and around the retry and heartbeat boundaries
         case ($urandom_range(0, 4))
            0: hold = state_sent_at + retry_cfg - $urandom_range(0, 1);
            1: hold = ping_sent_at + heartbeat_cfg - $urandom_range(0, 1);
            default: begin
               now_ms_sim += $urandom_range(0, retry_cfg + 200);
               hold = now_ms_sim;
            end
         endcase
         send_word(OP_TICK, hold, 1'($urandom_range(0, 1)), $urandom);
      end else if (pick < 88) begin
         now_ms_sim += $urandom_range(0, 300);
         send_word(OP_QUERY, ($urandom_range(0, 4) == 0) ? $urandom : now_ms_sim,
                   1'($urandom_range(0, 1)), $urandom);
      end else begin
         send_word(3'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)), $urandom);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_power_on_defaults();
      send_word(OP_QUERY, 32'd0, 1'b0, 32'd0);           // breathing at its floor
      send_word(OP_QUERY, 32'd1000, 1'b0, 32'd0);        // breathing peak
      send_word(OP_QUERY, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_word(OP_TICK, 32'd4999, 1'b0, 32'd0);         // one short of the first ping
      send_word(OP_TICK, 32'd5000, 1'b0, 32'd0);
   endtask

   task automatic test_debounce_reports();
      send_word(OP_SAMPLE, 32'd6000, 1'b0, 32'd0);       // nothing stable yet
      send_word(OP_SAMPLE, 32'd6050, 1'b0, 32'd0);       // first report, level off
      send_word(OP_SAMPLE, 32'd6100, 1'b1, 32'd0);
      send_word(OP_SAMPLE, 32'd6120, 1'b0, 32'd0);       // bounce restarts the wait
      send_word(OP_SAMPLE, 32'd6130, 1'b1, 32'd0);
      send_word(OP_SAMPLE, 32'd6179, 1'b1, 32'd0);       // 1 ms short
      send_word(OP_SAMPLE, 32'd6180, 1'b1, 32'd0);       // report, level on
   endtask

   task automatic test_ack_and_error();
      send_word(OP_ACK, 32'd0, 1'b0, 32'd2);             // wrong level
      send_word(OP_ACK, 32'd0, 1'b1, 32'd1);             // stale sequence
      send_word(OP_TICK, 32'd6680, 1'b0, 32'd0);         // retry due, no ping
      send_word(OP_ACK, 32'd0, 1'b1, 32'd2);             // confirmed on
      send_word(OP_QUERY, 32'd7000, 1'b0, 32'd0);
      send_word(OP_ACK, 32'd0, 1'b1, 32'd2);             // nothing awaited now
      send_word(OP_ERROR, 32'd0, 1'b0, 32'd3);           // wrong sequence
      send_word(OP_ERROR, 32'd0, 1'b0, 32'd2);           // error without a pending ack
      send_word(OP_QUERY, 32'd7000, 1'b0, 32'd0);        // blink, lit half
      send_word(OP_QUERY, 32'd7125, 1'b0, 32'd0);        // blink, dark half
   endtask

   task automatic test_off_and_double_tick();
      send_word(OP_SAMPLE, 32'd8000, 1'b0, 32'd0);
      send_word(OP_SAMPLE, 32'd8050, 1'b0, 32'd0);
      send_word(OP_TICK, 32'd10000, 1'b0, 32'd0);        // re-send and ping together
      send_word(OP_ACK, 32'd0, 1'b0, 32'd3);             // confirmed off
      send_word(OP_QUERY, 32'd10001, 1'b1, 32'd0);
   endtask

   task automatic test_spare_codes();
      send_word(OP_SPARE5, $urandom, 1'b1, $urandom);
      send_word(OP_SPARE6, $urandom, 1'b0, $urandom);
      send_word(OP_SPARE7, $urandom, 1'b1, $urandom);
      // a write past the last register must leave the heartbeat alone
      pause_until_drained();
      poke_register(CSR_SPARE, 16'h0000);
      send_word(OP_TICK, 32'd14999, 1'b0, 32'd0);
      send_word(OP_TICK, 32'd15000, 1'b0, 32'd0);
   endtask

   task automatic test_output_backpressure();
      // receiver holds off while the sender keeps offering words
      holds_asked <= holds_asked + 1;
      now_ms_sim = 32'd20000;
      repeat (40) begin
         now_ms_sim += $urandom_range(0, 700);
         if ($urandom_range(0, 3) == 0)
            send_word(OP_TICK, now_ms_sim, 1'($urandom_range(0, 1)), $urandom);
         else
            send_word(OP_QUERY, now_ms_sim, 1'($urandom_range(0, 1)), $urandom);
      end
      pause_until_drained();
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] deb, input logic [CSR_W-1:0] rty,
                            input logic [CSR_W-1:0] hb, input bit steady);
      int goal;
      set_config(deb, rty, hb);
      now_ms_sim = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                               : $urandom;
      calm = steady;
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) random_item();
      calm = 1'b0;
      phases_run++;
   endtask

   task automatic test_random_traffic();
      run_phase(16'd0, 16'd0, 16'd0, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      run_phase(16'($urandom_range(1, 200)), 16'($urandom_range(1, 900)),
                16'($urandom_range(1, 3000)), 1'b1);
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      run_phase(16'($urandom_range(0, 100)), 16'($urandom_range(0, 400)),
                16'($urandom_range(0, 1500)), 1'b0);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      // predictor starts from the power-on state
      debounce_cfg  = DEBOUNCE_RESET;
      retry_cfg     = RETRY_RESET;
      heartbeat_cfg = HEARTBEAT_RESET;
      cand_seen     = 1'b0;
      cand_lvl      = 1'b0;
      cand_since    = '0;
      stable_seen   = 1'b0;
      stable_lvl    = 1'b0;
      seq_now       = '0;
      ack_wait      = 1'b0;
      conf_now      = CONF_UNKNOWN;
      state_sent_at = '0;
      ping_sent_at  = '0;
      now_ms_sim    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_on_defaults();
      test_debounce_reports();
      test_ack_and_error();
      test_off_and_double_tick();
      test_spare_codes();
      test_output_backpressure();
      test_random_traffic();
      pause_until_drained();

      $display("Sent %0d operation words over %0d random register settings; %0d results checked.",
               words_sent, phases_run, msgs_checked);
      $display("Debounce, ack and error matching, retry, heartbeat, all LED modes, back-pressure.");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/dsr_pkg.sv
rtl/core/dsr_ctrl.sv
rtl/core/dsr_bright.sv
rtl/core/dsr_out.sv
rtl/core/debounced_switch_report_with_ack_retry_top.sv
rtl/core/dsr_checker.sv
bench/debounced_switch_report_with_ack_retry_top_test.sv
